### rtl/core/merge_insertion_sorter_core_defines.svh
// assertion macros shared by the sorter core
// the assertions sample on clk and are disabled while rst_n is low
`ifndef MERGE_INSERTION_SORTER_CORE_DEFINES_SVH
`define MERGE_INSERTION_SORTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MIS_ASSERT_IMP(lbl, ante, cons, msg)
`define MIS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/mis_pkg.sv
`default_nettype none

package mis_pkg;

  localparam int unsigned VAL_W = 31;

  typedef logic [VAL_W-1:0] val_t;

  // what a cell hands to the cell above it
  typedef struct packed {
    logic gt;
    val_t val;
  } cell_link_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/mis_if.sv
`default_nettype none

interface mis_in_if;
  logic          valid;
  logic          ready;
  mis_pkg::val_t value;
  logic          last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface mis_out_if;
  logic          valid;
  logic          ready;
  mis_pkg::val_t sorted_value;
  logic          last_out;
  logic          overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/mis_cell.sv
`default_nettype none

module mis_cell (
  input  wire                      clk,
  input  wire mis_pkg::cell_ctrl_t ctl,
  input  wire mis_pkg::val_t       ins_val,
  input  wire                      occ,
  input  wire mis_pkg::cell_link_t prev,
  input  wire mis_pkg::val_t       next_val,
  output mis_pkg::cell_link_t      link
);

  mis_pkg::val_t val_r;
  mis_pkg::val_t val_nxt;
  logic          gt_self;

  // an empty cell acts as plus infinity
  assign gt_self = !occ || (val_r > ins_val);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && gt_self) begin
      // the item lands here unless the cell below is also larger
      val_nxt = prev.gt ? prev.val : ins_val;
    end else if (ctl.shift) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link.gt  = gt_self;
  assign link.val = val_r;

endmodule

`default_nettype wire

### rtl/core/merge_insertion_sorter_core.sv
// Sorts a set of up to CAPACITY 31-bit unsigned values. Values are loaded one item per
// cycle; a row of CAPACITY cells keeps them in ascending order, each cell comparing its
// entry with the incoming value so that every value is placed in the cycle it is taken.
// The item marked last_in starts delivery: from the next cycle the set leaves in
// ascending order, one item per cycle while out_ch.ready is high, duplicates kept, the
// final one carrying last_out. While a set is being delivered no input is taken. Values
// beyond CAPACITY are dropped and overflow is raised on every result item of that set.
`default_nettype none
`include "merge_insertion_sorter_core_defines.svh"

module merge_insertion_sorter_core #(
  parameter int unsigned CAPACITY = 64
) (
  input wire      clk,
  input wire      rst_n,
  mis_in_if.sink  in_ch,
  mis_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             drain_r, drain_nxt;
  logic             ovf_r, ovf_nxt;

  logic in_acc, out_acc, ins_ok;
  mis_pkg::cell_ctrl_t ctl;
  mis_pkg::cell_link_t links [CAPACITY];

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign ins_ok  = fill_r < CAP_CNT;

  assign ctl.ins   = in_acc && ins_ok;
  assign ctl.shift = out_acc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    mis_pkg::cell_link_t prev_link;
    mis_pkg::val_t       next_val;

    if (i == 0) begin : g_bot
      assign prev_link.gt  = 1'b0;
      assign prev_link.val = in_ch.value;
    end else begin : g_mid
      assign prev_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_val = links[i].val;
    end else begin : g_low
      assign next_val = links[i+1].val;
    end

    mis_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .ins_val  (in_ch.value),
      .occ      (fill_r > IDX),
      .prev     (prev_link),
      .next_val (next_val),
      .link     (links[i])
    );
  end

  always_comb begin
    fill_nxt  = fill_r;
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (in_acc) begin
      if (ins_ok) begin
        fill_nxt = fill_r + ONE_CNT;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_ch.last_in) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_acc) begin
      fill_nxt = fill_r - ONE_CNT;
      if (fill_r == ONE_CNT) begin
        drain_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign in_ch.ready         = !drain_r;
  assign out_ch.valid        = drain_r;
  assign out_ch.sorted_value = links[0].val;
  assign out_ch.last_out     = (fill_r == ONE_CNT);
  assign out_ch.overflow     = ovf_r;

  `MIS_ASSERT_IMP(a_fill_cap, 1'b1, fill_r <= CAP_CNT, "fill count above capacity")
  `MIS_ASSERT_NXT(a_last_starts, in_acc && in_ch.last_in, drain_r && (fill_r != '0),
                  "last item did not start delivery of a non-empty set")
  `MIS_ASSERT_NXT(a_drain_count, out_acc, fill_r == $past(fill_r) - ONE_CNT,
                  "fill count not stepped down on delivered item")
  `MIS_ASSERT_NXT(a_drain_end, out_acc && (fill_r == ONE_CNT), !drain_r && !ovf_r,
                  "delivery did not end after the final item")
  `MIS_ASSERT_IMP(a_order, fill_r >= CNT_W'(2), !(links[0].val > links[1].val),
                  "lowest two held values out of order")

endmodule

`default_nettype wire

### test/merge_insertion_sorter_core_tb.sv
`timescale 1ns / 1ps

module merge_insertion_sorter_core_tb;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    mis_pkg::val_t value;
    logic          last_in;
  } set_item_t;

  typedef struct {
    mis_pkg::val_t sorted_value;
    logic          last_out;
    logic          overflow;
  } sorted_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mis_in_if  in_ch ();
  mis_out_if out_ch ();

  merge_insertion_sorter_core #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_item_t      pending_items[$];
  sorted_result_t expected_results[$];

  // running copy of the block's store for the set being loaded
  mis_pkg::val_t held_values[$];
  logic          held_overflow;

  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  function automatic mis_pkg::val_t pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return mis_pkg::val_t'($urandom_range(0, 7));
      default: return mis_pkg::val_t'($urandom());
    endcase
  endfunction

  function automatic void queue_set(int unsigned count);
    set_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it.value   = pick_value();
      it.last_in = (i == count - 1);
      pending_items = {pending_items, it};
    end
  endfunction

  function automatic void queue_fixed_set(mis_pkg::val_t vals[$]);
    set_item_t it;
    foreach (vals[i]) begin
      it.value   = vals[i];
      it.last_in = (i == vals.size() - 1);
      pending_items = {pending_items, it};
    end
  endfunction

  // insert after every held value that is less or equal; on the marked item
  // the whole set goes out in order
  function automatic void load_value(set_item_t it);
    int unsigned    pos;
    sorted_result_t res;
    if (held_values.size() < CAPACITY) begin
      pos = held_values.size();
      while (pos > 0 && held_values[pos-1] > it.value) pos--;
      held_values.insert(pos, it.value);
    end else begin
      held_overflow = 1'b1;
    end
    if (it.last_in) begin
      foreach (held_values[i]) begin
        res.sorted_value = held_values[i];
        res.last_out     = (i == held_values.size() - 1);
        res.overflow     = held_overflow;
        expected_results = {expected_results, res};
      end
      held_values.delete();
      held_overflow = 1'b0;
    end
  endfunction

  function automatic void check_result();
    sorted_result_t exp_res;
    if (expected_results.size() == 0) begin
      $error("unexpected item: sorted_value %0d last_out %0b overflow %0b",
             out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
      mismatch_count++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (out_ch.sorted_value !== exp_res.sorted_value) begin
      $error("sorted_value: expected %0d, got %0d", exp_res.sorted_value,
             out_ch.sorted_value);
      mismatch_count++;
    end
    if (out_ch.last_out !== exp_res.last_out) begin
      $error("last_out: expected %0b, got %0b", exp_res.last_out, out_ch.last_out);
      mismatch_count++;
    end
    if (out_ch.overflow !== exp_res.overflow) begin
      $error("overflow: expected %0b, got %0b", exp_res.overflow, out_ch.overflow);
      mismatch_count++;
    end
    results_checked++;
  endfunction

  // driver: holds an item until taken, otherwise may leave a gap
  always @(posedge clk) begin
    logic gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        load_value(pending_items.pop_front());
        items_accepted++;
      end
      gap = !(items_accepted >= 100 && items_accepted < 180) &&
            ($urandom_range(0, 99) < IDLE_PCT);
      if (in_ch.valid && !in_ch.ready) begin
        // item still waiting, keep it on the bus
      end else if (pending_items.size() != 0 && !gap) begin
        in_ch.valid   <= 1'b1;
        in_ch.value   <= pending_items[0].value;
        in_ch.last_in <= pending_items[0].last_in;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks every taken result, stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      out_ch.ready <= (results_checked >= 100 && results_checked < 180) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready  = 1'b0;
    held_overflow = 1'b0;

    // single-element sets at both extremes, then mixed, descending,
    // ascending and all-equal sets
    queue_fixed_set('{mis_pkg::val_t'('1)});
    queue_fixed_set('{mis_pkg::val_t'(0)});
    queue_fixed_set('{mis_pkg::val_t'(5), mis_pkg::val_t'(0), mis_pkg::val_t'('1),
                      mis_pkg::val_t'(5), mis_pkg::val_t'(3), mis_pkg::val_t'(0),
                      mis_pkg::val_t'(1)});
    queue_fixed_set('{mis_pkg::val_t'(60), mis_pkg::val_t'(50), mis_pkg::val_t'(40),
                      mis_pkg::val_t'(30), mis_pkg::val_t'(20), mis_pkg::val_t'(10)});
    queue_fixed_set('{mis_pkg::val_t'(1), mis_pkg::val_t'(2), mis_pkg::val_t'(3),
                      mis_pkg::val_t'(4)});
    queue_fixed_set('{mis_pkg::val_t'(9), mis_pkg::val_t'(9), mis_pkg::val_t'(9)});

    // store exactly full, then one past full with the marked item dropped
    queue_set(CAPACITY);
    queue_set(CAPACITY + 1);
    while (pending_items.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: queue_set(CAPACITY);
        1: queue_set($urandom_range(CAPACITY + 1, CAPACITY + 6));
        default: queue_set($urandom_range(1, 8));
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while ((pending_items.size() != 0 || expected_results.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
